// ----- hdl/tten_pkg.sv -----
// ----------------------------------------------------------------------------
// tten_pkg
// Shared types, codes and constants for the timed trigger envelope table.
// ----------------------------------------------------------------------------
package tten_pkg;

    localparam int unsigned MAX_TRIGGERS_DEF = 64;
    localparam int unsigned START_W = 32;
    localparam int unsigned DUR_W   = 24;
    localparam int unsigned ENV_W   = 17;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IDX_W   = 6;
    localparam logic [ENV_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_EVAL   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOR  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_FIND,
        S_INS_SHIFT,
        S_INS_PUT,
        S_EV_RD,
        S_EV_CHK,
        S_EV_DIV,
        S_EV_ACC,
        S_RD_WAIT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the request fields
        logic ptr_init;   // ptr <= fill (insert) or 0 (evaluate)
        logic ptr_dec;
        logic ptr_inc;
        logic mem_rd;     // read entry at ptr-1 (insert) or ptr (evaluate)
        logic rd_lo;      // read address ptr instead of ptr-1
        logic mem_shift;  // write last read entry at ptr
        logic mem_put;    // write request entry at ptr
        logic fill_inc;
        logic ev_check;   // classify the fetched entry
        logic div_start;
        logic ev_acc;
        logic rd_idx;     // read at the requested index
        logic finish;     // drive the result beat
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic ptr_zero;
        logic ptr_end;    // ptr == fill
        logic ins_move;   // fetched start > new start
        logic active;
        logic div_done;
    } t_sts;

endpackage

// ----- hdl/tten_div.sv -----
// ----------------------------------------------------------------------------
// tten_div
// Restoring divider, one quotient bit per cycle: (elapsed << 16) / length.
// ----------------------------------------------------------------------------
module tten_div
    import tten_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DUR_W-1:0]     i_num,   // elapsed, below length
    input  logic [DUR_W-1:0]     i_den,
    output logic                 o_done,
    output logic [15:0]          o_quot
);
    logic [DUR_W:0]   r_rem, n_rem;
    logic [15:0]      r_quot;
    logic [DUR_W-1:0] r_den;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic [DUR_W+1:0] w_tr;

    assign w_tr  = {r_rem, 1'b0} - {2'b00, r_den};
    assign n_rem = w_tr[DUR_W+1] ? {r_rem[DUR_W-1:0], 1'b0} : w_tr[DUR_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[14:0], ~w_tr[DUR_W+1]};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
endmodule

// ----- hdl/tten_datapath.sv -----
// ----------------------------------------------------------------------------
// tten_datapath
// Entry memories, fill count, walk pointer, divider and envelope accumulator.
// ----------------------------------------------------------------------------
module tten_datapath
    import tten_pkg::*;
#(
    parameter int unsigned MAX_TRIGGERS = MAX_TRIGGERS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [1:0]           i_action,
    input  logic [START_W-1:0]   i_start_time,
    input  logic [DUR_W-1:0]     i_duration,
    input  logic [START_W-1:0]   i_query_time,
    input  logic [IDX_W-1:0]     i_entry_index,
    output logic                 o_valid,
    output logic [ENV_W-1:0]     o_envelope,
    output logic [CNT_W-1:0]     o_started_count,
    output logic [CNT_W-1:0]     o_entry_total,
    output logic [START_W-1:0]   o_read_start,
    output logic [DUR_W-1:0]     o_read_duration,
    output logic [1:0]           o_status
);
    localparam int unsigned AW = $clog2(MAX_TRIGGERS);
    localparam int unsigned FW = $clog2(MAX_TRIGGERS + 1);

    logic [START_W-1:0] mem_st [MAX_TRIGGERS];
    logic [DUR_W-1:0]   mem_du [MAX_TRIGGERS];

    logic [1:0]         r_act;
    logic [START_W-1:0] r_st, r_qt;
    logic [DUR_W-1:0]   r_du;
    logic [IDX_W-1:0]   r_idx;
    logic [FW-1:0]      r_fill, r_ptr;
    logic [START_W-1:0] r_rst;
    logic [DUR_W-1:0]   r_rdu;
    logic [ENV_W:0]     r_sum;
    logic [FW-1:0]      r_started;
    logic               r_counting, r_act_ok;
    logic               r_was_full;
    logic [DUR_W-1:0]   r_elap;
    logic               div_done;
    logic [15:0]        div_q;
    logic [FW-1:0]      w_raddr;
    logic               w_idx_ok;
    logic [START_W:0]   w_el;

    assign w_idx_ok = ({{(FW > IDX_W ? FW-IDX_W : 0){1'b0}}, r_idx} < r_fill);
    assign w_raddr  = i_cmd.rd_idx ? FW'(r_idx)
                    : (i_cmd.rd_lo ? r_ptr : r_ptr - FW'(1));
    assign w_el     = {1'b0, r_qt} - {1'b0, r_rst};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rst <= mem_st[w_raddr[AW-1:0]];
            r_rdu <= mem_du[w_raddr[AW-1:0]];
        end
        if (i_cmd.mem_shift) begin
            mem_st[r_ptr[AW-1:0]] <= r_rst;
            mem_du[r_ptr[AW-1:0]] <= r_rdu;
        end else if (i_cmd.mem_put) begin
            mem_st[r_ptr[AW-1:0]] <= r_st;
            mem_du[r_ptr[AW-1:0]] <= r_du;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_st  <= i_start_time;
            r_du  <= i_duration;
            r_qt  <= i_query_time;
            r_idx <= i_entry_index;
            r_sum <= '0;
            r_started  <= '0;
            r_counting <= 1'b1;
            r_was_full <= (r_fill == FW'(MAX_TRIGGERS));
        end
        if (i_cmd.ptr_init) r_ptr <= (r_act == ACT_INSERT) ? r_fill : '0;
        else if (i_cmd.ptr_dec) r_ptr <= r_ptr - FW'(1);
        else if (i_cmd.ptr_inc) r_ptr <= r_ptr + FW'(1);
        if (i_cmd.ev_check) begin
            // t >= start, t < start + length, nonzero length
            r_act_ok <= !w_el[START_W] && (r_rdu != '0)
                        && (w_el[START_W-1:0] < {8'd0, r_rdu});
            r_elap   <= w_el[DUR_W-1:0];
            if (r_counting && !w_el[START_W]) r_started <= r_started + FW'(1);
            else r_counting <= 1'b0;
        end
        // hold the sum once it is past one, so it never wraps
        if (i_cmd.ev_acc && (r_sum <= {1'b0, ONE_Q16})) begin
            r_sum <= r_sum + ({1'b0, ONE_Q16} - {2'b00, div_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
            if (i_cmd.fill_inc) r_fill <= r_fill + FW'(1);
        end
    end

    tten_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_elap),
        .i_den   (r_rdu),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // result beat registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_envelope      <= '0;
            o_started_count <= '0;
            o_read_start    <= '0;
            o_read_duration <= '0;
            o_status        <= ST_OK;
            o_entry_total   <= CNT_W'(r_fill);
            case (r_act)
                ACT_INSERT: if (r_was_full) o_status <= ST_FULL;
                ACT_EVAL: begin
                    o_envelope      <= (r_sum > {1'b0, ONE_Q16}) ? ONE_Q16
                                                                 : r_sum[ENV_W-1:0];
                    o_started_count <= CNT_W'(r_started);
                end
                ACT_READ: begin
                    if (w_idx_ok) begin
                        o_read_start    <= r_rst;
                        o_read_duration <= r_rdu;
                    end else begin
                        o_status <= ST_OOR;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.full     = (r_fill == FW'(MAX_TRIGGERS));
    assign o_sts.ptr_zero = (r_ptr == '0);
    assign o_sts.ptr_end  = (r_ptr == r_fill);
    assign o_sts.ins_move = (r_rst > r_st);
    assign o_sts.active   = r_act_ok;
    assign o_sts.div_done = div_done;
endmodule

// ----- hdl/tten_ctrl.sv -----
// ----------------------------------------------------------------------------
// tten_ctrl
// Sequencer for insert shift, evaluate walk and indexed read.
// ----------------------------------------------------------------------------
module tten_ctrl
    import tten_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy
);
    t_state r_state, n_state;
    logic   r_act_ins, r_act_ev, r_act_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act_ins <= 1'b0;
            r_act_ev  <= 1'b0;
            r_act_rd  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) begin
                r_act_ins <= (i_action == ACT_INSERT);
                r_act_ev  <= (i_action == ACT_EVAL);
                r_act_rd  <= (i_action == ACT_READ);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: if (i_start) begin
                o_cmd.load = 1'b1;
                n_state    = S_RD_WAIT;
            end
            // wait state lets the captured action settle, then dispatch
            S_RD_WAIT: begin
                if (r_act_ins) begin
                    if (i_sts.full) n_state = S_DONE;
                    else begin
                        o_cmd.ptr_init = 1'b1;
                        n_state = S_INS_FIND;
                    end
                end else if (r_act_ev) begin
                    o_cmd.ptr_init = 1'b1;
                    n_state = S_EV_RD;
                end else if (r_act_rd) begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_idx = 1'b1;
                    n_state = S_DONE;
                end else n_state = S_DONE;
            end
            S_INS_FIND: begin
                if (i_sts.ptr_zero) n_state = S_INS_PUT;
                else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                // move the larger entry up one slot, else stop here
                if (i_sts.ins_move) begin
                    o_cmd.mem_shift = 1'b1;
                    o_cmd.ptr_dec   = 1'b1;
                    n_state = S_INS_FIND;
                end else n_state = S_INS_PUT;
            end
            S_INS_PUT: begin
                o_cmd.mem_put  = 1'b1;
                o_cmd.fill_inc = 1'b1;
                n_state = S_DONE;
            end
            S_EV_RD: begin
                if (i_sts.ptr_end) n_state = S_DONE;
                else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_lo  = 1'b1;
                    n_state = S_EV_CHK;
                end
            end
            S_EV_CHK: begin
                o_cmd.ev_check = 1'b1;
                n_state = S_EV_DIV;
            end
            S_EV_DIV: begin
                if (i_sts.active) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_EV_ACC;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state = S_EV_RD;
                end
            end
            S_EV_ACC: if (i_sts.div_done) begin
                o_cmd.ev_acc  = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                n_state = S_EV_RD;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- hdl/timed_trigger_envelope_table.sv -----
// ----------------------------------------------------------------------------
// timed_trigger_envelope_table
// Sorted trigger table with summed linear-decay envelope evaluation.
// ----------------------------------------------------------------------------
// Read fetches the indexed entry; a full-table insert reports full;
// other inserts walk down from the top, moving each larger start up a slot,
// then write it. Evaluate walks all entries, dividing for each active one.
// One item at a time: busy stays high until the result strobe.
// The result beat lasts one cycle; the receiver cannot stall it.
// Reset clears the entry count and the controller; memories keep contents.
module timed_trigger_envelope_table
    import tten_pkg::*;
#(
    parameter int unsigned MAX_TRIGGERS = MAX_TRIGGERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [START_W-1:0] i_start_time,
    input  logic [DUR_W-1:0]   i_duration,
    input  logic [START_W-1:0] i_query_time,
    input  logic [IDX_W-1:0]   i_entry_index,
    output logic               o_valid,
    output logic [ENV_W-1:0]   o_envelope,
    output logic [CNT_W-1:0]   o_started_count,
    output logic [CNT_W-1:0]   o_entry_total,
    output logic [START_W-1:0] o_read_start,
    output logic [DUR_W-1:0]   o_read_duration,
    output logic [1:0]         o_status
);
    t_cmd cmd;
    t_sts sts;

    tten_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tten_datapath #(.MAX_TRIGGERS(MAX_TRIGGERS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_start_time    (i_start_time),
        .i_duration      (i_duration),
        .i_query_time    (i_query_time),
        .i_entry_index   (i_entry_index),
        .o_valid         (o_valid),
        .o_envelope      (o_envelope),
        .o_started_count (o_started_count),
        .o_entry_total   (o_entry_total),
        .o_read_start    (o_read_start),
        .o_read_duration (o_read_duration),
        .o_status        (o_status)
    );

    a_env_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_envelope <= ONE_Q16) else $error("envelope above one");
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while still busy");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_started_count <= o_entry_total)
        else $error("started count above entry total");
endmodule
